// ----- hdl/mbb_pkg.sv -----
// Shared constants, codes and interface types of the page framebuffer blitter.
package mbb_pkg;

  // Display geometry and the derived framebuffer size
  localparam int DISPLAY_WIDTH  = 88;
  localparam int DISPLAY_HEIGHT = 48;
  localparam int FB_PAGES       = (DISPLAY_HEIGHT + 7) / 8;
  localparam int FB_BYTES       = DISPLAY_WIDTH * FB_PAGES;
  localparam int ADDR_W         = $clog2(FB_BYTES);

  // One lane per bit of a source byte
  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);

  // Signed screen position: 8-bit origin plus 8-bit offset
  localparam int POS_W = 10;

  // Operation codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BMP_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BMP_HEIGHT = 2'd3;

  localparam logic [7:0] BMP_WIDTH_RST  = 8'd16;
  localparam logic [7:0] BMP_HEIGHT_RST = 8'd16;

  // What one lane found for its pixel
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } lane_t;

  // Request into the framebuffer engine, valid for one cycle
  typedef struct packed {
    logic                    draw;
    logic                    read;
    logic                    rd_oor;
    logic [ADDR_W-1:0]       raddr;
    logic [7:0]              pix;
    lane_t [LANES-1:0]       lanes;
  } fb_req_t;

  // Engine status
  typedef struct packed {
    logic ready;
    logic clearing;
    logic walking;
    logic rd_pend;
  } fb_stat_t;

  // Read response
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } fb_rsp_t;

endpackage

// ----- hdl/mbb_lane.sv -----
// One pixel lane: clips one bitmap bit and forms its framebuffer byte address.
module mbb_lane import mbb_pkg::*; (
  input  logic              bit_on,
  input  logic [7:0]        col,
  input  logic [7:0]        bmp_width,
  input  logic [7:0]        origin_x,
  input  logic              row_ok,
  input  logic [ADDR_W-1:0] page_base,
  output lane_t             lane
);

  logic [POS_W-1:0] sx;

  // Screen column: sign-extended origin plus bitmap column
  assign sx = {{(POS_W-8){origin_x[7]}}, origin_x} + {{(POS_W-8){1'b0}}, col};

  // Keep the pixel only when set, inside the icon and on screen
  assign lane.hit = row_ok && bit_on && (col < bmp_width) && !sx[POS_W-1] &&
                    (sx[POS_W-2:0] < (POS_W-1)'(DISPLAY_WIDTH));

  assign lane.addr = page_base + ADDR_W'(sx[POS_W-2:0]);

endmodule

// ----- hdl/mbb_fb.sv -----
// Framebuffer memory with clearing pass, merge register and read-modify-write walker.
module mbb_fb import mbb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fb_req_t  req,
  input  logic     out_free,
  output fb_stat_t stat,
  output fb_rsp_t  rsp
);

  logic [7:0] mem [FB_BYTES];

  logic                          clearing;
  logic [ADDR_W-1:0]             clr_cnt;
  logic [LANES-1:0]              hits;
  logic [LANES-1:0][ADDR_W-1:0]  addrs;
  logic [LANES-1:0]              hits_in;
  logic [LANES-1:0][ADDR_W-1:0]  addrs_in;
  logic [7:0]                    pix;
  logic                          wr_pend;
  logic [ADDR_W-1:0]             wr_addr;
  logic                          rd_pend;
  logic                          rd_oor;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          rsp_valid;
  logic                          rsp_oor;
  logic [7:0]                    mem_q;
  logic [LANE_W-1:0]             pick;
  logic                          walking;
  logic                          rd_issue;
  logic                          mem_re;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_ra;
  logic [ADDR_W-1:0]             mem_wa;
  logic [7:0]                    mem_wd;

  // Merge the lane results into a hit mask and address list
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      hits_in[i]  = req.lanes[i].hit;
      addrs_in[i] = req.lanes[i].addr;
    end
  end

  // Pick the lowest lane still waiting
  always_comb begin
    pick = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        pick = LANE_W'(i);
      end
    end
  end

  assign walking  = |hits;
  assign rd_issue = rd_pend && out_free;

  // Memory port selection: walker read, host read, write-back or clear
  assign mem_re = walking || (rd_issue && !rd_oor);
  assign mem_ra = walking ? addrs[pick] : rd_addr;
  assign mem_we = clearing || wr_pend;
  assign mem_wa = clearing ? clr_cnt : wr_addr;
  assign mem_wd = clearing ? 8'd0 : (mem_q | pix);

  assign stat.ready    = !clearing && !walking && !rd_pend;
  assign stat.clearing = clearing;
  assign stat.walking  = walking;
  assign stat.rd_pend  = rd_pend;

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_oor ? 8'd0 : mem_q;

  // Sequence clearing, the pixel walk and host reads
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      hits      <= '0;
      wr_pend   <= 1'b0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == ADDR_W'(FB_BYTES - 1)) begin
          clearing <= 1'b0;
        end
      end

      wr_pend <= walking;
      if (walking) begin
        wr_addr     <= addrs[pick];
        hits[pick]  <= 1'b0;
      end

      rsp_valid <= rd_issue;
      if (rd_issue) begin
        rd_pend <= 1'b0;
        rsp_oor <= rd_oor;
      end

      if (stat.ready && req.draw) begin
        hits  <= hits_in;
        addrs <= addrs_in;
        pix   <= req.pix;
      end
      if (stat.ready && req.read) begin
        rd_pend <= 1'b1;
        rd_addr <= req.raddr;
        rd_oor  <= req.rd_oor;
      end
    end
  end

  // Framebuffer store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

endmodule

// ----- hdl/mono_bitmap_blit_page_framebuffer_core.sv -----
// Top level of the page-organised monochrome framebuffer with bitmap blitter.
//
// Input channel (in_valid/in_stall): op selects a draw of one bitmap byte
// (src_row, src_byte_col, src_byte) or a read of one framebuffer byte
// (read_addr). Output channel (out_valid/out_stall) carries read_data, one
// beat per read; draws give no beat. Configuration (cfg_valid/cfg_ready,
// always ready) writes origin_x, origin_y, bitmap width and height by index.
//
// Eight lanes clip the eight pixels of a draw beat in the accept cycle; the
// engine then does one read-modify-write per visible pixel on a memory with
// one read and one write port. A draw holds the input until the walker has
// read every pixel that lands. A read holds it until it is issued, which
// waits for a free output register; read_data passes through the registered
// memory read and the output register. Out-of-range read addresses return zero.
//
// After reset the engine clears all 528 framebuffer bytes, one per cycle,
// with in_stall high; configuration writes are taken throughout. When the
// receiver stalls, a finished beat waits in the output register; draws are
// still accepted, and a further read waits until that beat is taken.
module mono_bitmap_blit_page_framebuffer_core import mbb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [7:0]           src_row,
  input  logic [4:0]           src_byte_col,
  input  logic [7:0]           src_byte,
  input  logic [9:0]           read_addr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           read_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0]             origin_x;
  logic [7:0]             origin_y;
  logic [7:0]             bmp_width;
  logic [7:0]             bmp_height;
  logic [POS_W-1:0]       sy;
  logic                   row_ok;
  logic [ADDR_W-1:0]      page_base;
  logic                   in_accept;
  logic                   out_free;
  lane_t [LANES-1:0]      lanes;
  fb_req_t                req;
  fb_stat_t               stat;
  fb_rsp_t                rsp;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= 8'd0;
      origin_y   <= 8'd0;
      bmp_width  <= BMP_WIDTH_RST;
      bmp_height <= BMP_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X:   origin_x   <= cfg_data;
        REG_ORIGIN_Y:   origin_y   <= cfg_data;
        REG_BMP_WIDTH:  bmp_width  <= cfg_data;
        REG_BMP_HEIGHT: bmp_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Screen row, shared by all lanes
  assign sy = {{(POS_W-8){origin_y[7]}}, origin_y} + {{(POS_W-8){1'b0}}, src_row};
  assign row_ok = (src_row < bmp_height) && !sy[POS_W-1] &&
                  (sy[POS_W-2:0] < (POS_W-1)'(DISPLAY_HEIGHT));
  assign page_base = ADDR_W'(32'(sy[POS_W-2:3]) * DISPLAY_WIDTH);

  // Pixel lanes, MSB of the source byte is the leftmost column
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mbb_lane u_lane (
      .bit_on     (src_byte[LANES-1-g]),
      .col        ({src_byte_col, LANE_W'(g)}),
      .bmp_width  (bmp_width),
      .origin_x   (origin_x),
      .row_ok     (row_ok),
      .page_base  (page_base),
      .lane       (lanes[g])
    );
  end

  // Input handshake and request to the engine
  assign in_stall  = !stat.ready;
  assign in_accept = in_valid && !in_stall;

  assign req.draw   = in_accept && (op == OP_DRAW);
  assign req.read   = in_accept && (op == OP_READ);
  assign req.rd_oor = 32'(read_addr) >= FB_BYTES;
  assign req.raddr  = ADDR_W'(read_addr);
  assign req.pix    = 8'd1 << sy[2:0];
  assign req.lanes  = lanes;

  // A read may go out only if its beat will find the output register free
  assign out_free = !rsp.valid && (!out_valid || !out_stall);

  mbb_fb u_fb (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .out_free (out_free),
    .stat     (stat),
    .rsp      (rsp)
  );

  // Output register: load a read beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp.valid) begin
      out_valid <= 1'b1;
      read_data <= rsp.data;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // A read beat never lands on a beat still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (!out_valid || !out_stall))
    else $error("read beat would overwrite a waiting output beat");

  // The engine does one job at a time
  a_one_job: assert property (@(posedge clk) disable iff (rst)
    $onehot0({stat.clearing, stat.walking, stat.rd_pend}))
    else $error("engine busy with more than one job");

  // Every read beat follows an issued read request
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $past(stat.rd_pend && out_free))
    else $error("read beat without an issued request");

endmodule
